// ----- sv/lir_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the linear interpolation resampler.
// No dependencies; imported by every module of the block.
package lir_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_RUN_DEF   = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam int SAMPLE_W  = 16;
  localparam int STEP_W    = 20;
  localparam int CC_W      = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [STEP_W-1:0]    STEP_RESET = 20'd65536;
  localparam logic [CC_W-1:0]      CC_RESET   = 2'd2;
  localparam logic [CC_W-1:0]      CC_MONO    = 2'd1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'b1;

  // One frame as handed from the front end to the back end
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] prev_left;
    logic signed [SAMPLE_W-1:0] prev_right;
    logic signed [SAMPLE_W-1:0] cur_left;
    logic signed [SAMPLE_W-1:0] cur_right;
    logic                       has_prev;
    logic                       fin;
  } job_t;

endpackage

// ----- sv/lir_front.sv -----
`timescale 1ns / 1ps
// Front end: config registers, step clamp, input accept and frame history.
// Depends on lir_pkg.
module lir_front import lir_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [STEP_W-1:0]          cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_left,
  input  logic signed [SAMPLE_W-1:0] in_right,
  input  logic                       final_sample,
  output logic                       push_valid,
  input  logic                       push_ready,
  output job_t                       push_data,
  output logic [FRAC_BITS+3:0]       step_clamped,
  output logic                       mono
);

  localparam int PW = FRAC_BITS + 4;
  localparam int CW = (PW > STEP_W) ? PW : STEP_W;
  localparam logic [CW-1:0] STEP_MIN = CW'(1) << (FRAC_BITS - 4);
  localparam logic [CW-1:0] STEP_MAX = CW'(8) << FRAC_BITS;

  logic [STEP_W-1:0]          step;
  logic [CC_W-1:0]            channel_count;
  logic signed [SAMPLE_W-1:0] prev_left;
  logic signed [SAMPLE_W-1:0] prev_right;
  logic                       have_prev;
  logic [CW-1:0]              step_ext;
  logic                       in_beat;

  assign cfg_ready = 1'b1;
  assign mono      = (channel_count == CC_MONO);

  always_comb begin
    step_ext = CW'(step);
    if (step_ext < STEP_MIN) begin
      step_clamped = STEP_MIN[PW-1:0];
    end else if (step_ext > STEP_MAX) begin
      step_clamped = STEP_MAX[PW-1:0];
    end else begin
      step_clamped = step_ext[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= STEP_RESET;
      channel_count <= CC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP:     step          <= cfg_data;
        REG_CHANNELS: channel_count <= cfg_data[CC_W-1:0];
        default:      ;
      endcase
    end
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign in_beat    = in_valid && in_ready;

  always_comb begin
    push_data.prev_left  = prev_left;
    push_data.prev_right = prev_right;
    push_data.cur_left   = in_left;
    push_data.cur_right  = in_right;
    push_data.has_prev   = have_prev;
    push_data.fin        = final_sample;
  end

  // A final frame closes the segment: history goes back to empty
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left  <= '0;
      prev_right <= '0;
      have_prev  <= 1'b0;
    end else if (in_beat) begin
      if (final_sample) begin
        prev_left  <= '0;
        prev_right <= '0;
        have_prev  <= 1'b0;
      end else begin
        prev_left  <= in_left;
        prev_right <= in_right;
        have_prev  <= 1'b1;
      end
    end
  end

endmodule

// ----- sv/lir_queue.sv -----
`timescale 1ns / 1ps
// Short frame queue between front end and back end.
// Depends on lir_pkg (job_t, QUEUE_DEPTH).
module lir_queue import lir_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  job_t          entries [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != NW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst) begin
      assert (count <= NW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    end
  end

endmodule

// ----- sv/lir_back.sv -----
`timescale 1ns / 1ps
// Back end: phase walker, multiply stage and rounding output register.
// Depends on lir_pkg (job_t).
module lir_back import lir_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_RUN   = MAX_RUN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  job_t                       q_data,
  input  logic [FRAC_BITS+3:0]       step_clamped,
  input  logic                       mono,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_left,
  output logic signed [SAMPLE_W-1:0] out_right,
  output logic                       last_of_run
);

  localparam int PW  = FRAC_BITS + 4;
  localparam int NW  = $clog2(MAX_RUN + 1);
  localparam int PRW = FRAC_BITS + SAMPLE_W + 2;
  localparam logic [PW-1:0] ONE       = PW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] PHASE_LIM = PW'(9) << FRAC_BITS;

  // walker state
  logic          busy;
  job_t          job;
  logic [PW-1:0] phase;
  logic [PW-1:0] phase_next;
  logic [NW-1:0] n;

  // multiply stage
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_base_l;
  logic signed [SAMPLE_W-1:0] s1_base_r;
  logic signed [PRW-1:0]      s1_prod_l;
  logic signed [PRW-1:0]      s1_prod_r;
  logic                       s1_last;

  logic                       s1_adv;
  logic                       s2_adv;
  logic                       step_go;
  logic                       phase_lt;
  logic [PW-1:0]              phase_add;
  logic                       emit;
  logic                       done;
  logic                       last;
  logic signed [SAMPLE_W:0]   diff_l;
  logic signed [SAMPLE_W:0]   diff_r;
  logic signed [FRAC_BITS:0]  frac_s;

  // (base * 2^F + prod) / 2^F, truncated toward zero
  function automatic logic [SAMPLE_W-1:0] lerp_round(
    input logic signed [SAMPLE_W-1:0] base,
    input logic signed [PRW-1:0]      prod
  );
    logic signed [PRW-1:0] num;
    logic signed [PRW-1:0] q;
    num = ({{(PRW-SAMPLE_W){base[SAMPLE_W-1]}}, base} << FRAC_BITS) + prod;
    q   = num >>> FRAC_BITS;
    if (num[PRW-1] && (num[FRAC_BITS-1:0] != '0)) begin
      q = q + PRW'(1);
    end
    return q[SAMPLE_W-1:0];
  endfunction

  assign s2_adv = !out_valid || out_ready;
  assign s1_adv = !s1_valid || s2_adv;

  always_comb begin
    step_go   = busy && s1_adv;
    phase_lt  = (phase < ONE);
    phase_add = phase + step_clamped;
    emit      = step_go && job.has_prev && phase_lt && (n < NW'(MAX_RUN));
    done      = step_go && (!job.has_prev || !phase_lt || (phase_add >= ONE));
    last      = done || (n == NW'(MAX_RUN - 1));
    q_ready   = !busy || done;

    phase_next = phase;
    if (step_go) begin
      if (!job.has_prev) begin
        phase_next = '0;
      end else if (!phase_lt) begin
        phase_next = phase - ONE;
      end else if (phase_add >= ONE) begin
        phase_next = phase_add - ONE;
      end else begin
        phase_next = phase_add;
      end
      if (done && job.fin) begin
        phase_next = '0;
      end
    end

    diff_l = {job.cur_left[SAMPLE_W-1], job.cur_left}
           - {job.prev_left[SAMPLE_W-1], job.prev_left};
    diff_r = {job.cur_right[SAMPLE_W-1], job.cur_right}
           - {job.prev_right[SAMPLE_W-1], job.prev_right};
    frac_s = {1'b0, phase[FRAC_BITS-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= '0;
      n     <= '0;
    end else begin
      phase <= phase_next;
      if (q_valid && q_ready) begin
        busy <= 1'b1;
        job  <= q_data;
        n    <= '0;
      end else begin
        if (done) begin
          busy <= 1'b0;
        end
        if (emit) begin
          n <= n + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_base_l <= job.prev_left;
      s1_base_r <= job.prev_right;
      s1_prod_l <= PRW'(diff_l) * PRW'(frac_s);
      s1_prod_r <= PRW'(diff_r) * PRW'(frac_s);
      s1_last   <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      out_left    <= lerp_round(s1_base_l, s1_prod_l);
      out_right   <= mono ? '0 : lerp_round(s1_base_r, s1_prod_r);
      last_of_run <= s1_last;
    end
  end

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (n <= NW'(MAX_RUN)))
    else $error("run counter beyond limit");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    phase < PHASE_LIM)
    else $error("phase out of range");

  a_fresh_segment: assert property (@(posedge clk) disable iff (rst)
    (busy && !job.has_prev) |-> (phase == '0))
    else $error("segment start with nonzero phase");

  a_mono_right: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mono) |-> (out_right == '0))
    else $error("right channel not zero in mono mode");

endmodule

// ----- sv/linear_interp_resampler.sv -----
`timescale 1ns / 1ps
// Top level of the linear interpolation resampler.
// Depends on lir_pkg, lir_front, lir_queue, lir_back.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data (step, chans)
//  in       | in_valid / in_ready   | in_left, in_right, final_sample
//  out      | out_valid / out_ready | out_left, out_right, last_of_run
//
// The back end walks one read position per cycle unless a stalled output
// holds it; a frame covers up to 16 read positions at the smallest step,
// and none for a segment start or a frame the read position skips.
// A frame's first result passes the multiply register, then the rounding
// output register, before it appears at the output.
// Reset is synchronous; it restores step = 1.0, stereo, empty history.
// The front takes a beat whenever the two-entry frame queue has room, and a
// stalled output only freezes the back end walker and its two stages.
module linear_interp_resampler import lir_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_RUN   = MAX_RUN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [STEP_W-1:0]          cfg_data,
  // input frames
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_left,
  input  logic signed [SAMPLE_W-1:0] in_right,
  input  logic                       final_sample,
  // interpolated samples
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_left,
  output logic signed [SAMPLE_W-1:0] out_right,
  output logic                       last_of_run
);

  logic                   push_valid;
  logic                   push_ready;
  job_t                   push_data;
  logic                   q_valid;
  logic                   q_ready;
  job_t                   q_data;
  // Clamped step and channel mode are read live by the back end; the user must
  // change them only while no frame is in flight, as the block does not enforce it.
  logic [FRAC_BITS+3:0]   step_clamped;
  logic                   mono;

  lir_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_left      (in_left),
    .in_right     (in_right),
    .final_sample (final_sample),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data),
    .step_clamped (step_clamped),
    .mono         (mono)
  );

  // Frame queue decouples input acceptance from output generation
  lir_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  lir_back #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_RUN   (MAX_RUN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .step_clamped (step_clamped),
    .mono         (mono),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_left     (out_left),
    .out_right    (out_right),
    .last_of_run  (last_of_run)
  );

endmodule
